@@ src/scaled_overlay_alpha_blender_macros.svh @@
// ----------------------------------------------------------------------------
// scaled overlay alpha blender assertion macros
// shared assertion forms, clocked on aclk and held off during reset
// ----------------------------------------------------------------------------
`ifndef SCALED_OVERLAY_ALPHA_BLENDER_MACROS_SVH
`define SCALED_OVERLAY_ALPHA_BLENDER_MACROS_SVH

// same-cycle implication
`define SOB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SOB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sob_pkg.sv @@
// ----------------------------------------------------------------------------
// sob_pkg
// shared types, constants and helpers of the scaled overlay alpha blender
// ----------------------------------------------------------------------------
package sob_pkg;

    // default sizes
    localparam int unsigned OVERLAY_MAX_W_DEF   = 256;
    localparam int unsigned OVERLAY_MAX_H_DEF   = 256;
    localparam int unsigned FRAME_MAX_DIM_DEF   = 4096;
    localparam int unsigned SCALE_FRAC_BITS_DEF = 16;

    // field widths
    localparam int unsigned COORD_W = 12;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned SIZE_W  = 9;
    localparam int unsigned DRAW_W  = 13;
    localparam int unsigned SCALE_W = 24;
    localparam int unsigned PROD_W  = COORD_W + SCALE_W;
    localparam int unsigned SUM_W   = 2 * CHAN_W;
    localparam int unsigned TEXEL_W = 4 * CHAN_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = SCALE_W;

    // register reset values
    localparam logic [SIZE_W-1:0]  OVERLAY_SIZE_RST  = SIZE_W'(1);
    localparam logic [DRAW_W-1:0]  DRAW_SIZE_RST     = DRAW_W'(1);
    localparam logic [COORD_W-1:0] OFFSET_RST        = '0;
    localparam logic [SCALE_W-1:0] INVERSE_SCALE_RST = SCALE_W'(65536);

    localparam logic [CHAN_W-1:0] OPAQUE_MAX = 8'd255;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_BLEND = 1'b1
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERLAY_WIDTH  = 3'd0,
        CFG_OVERLAY_HEIGHT = 3'd1,
        CFG_DRAW_WIDTH     = 3'd2,
        CFG_DRAW_HEIGHT    = 3'd3,
        CFG_OFFSET_X       = 3'd4,
        CFG_OFFSET_Y       = 3'd5,
        CFG_INVERSE_SCALE  = 3'd6
    } cfg_idx_t;

    // last usable texel index along one axis, size clamped to 1..max
    function automatic logic [COORD_W-1:0] last_index(logic [SIZE_W-1:0] size,
                                                      int unsigned max_size);
        logic [COORD_W-1:0] res;
        if (size == '0) begin
            res = '0;
        end else if (32'(size) > max_size) begin
            res = COORD_W'(max_size - 1);
        end else begin
            res = COORD_W'(size - SIZE_W'(1));
        end
        return res;
    endfunction

    // exact x / 255 for x below 65280
    function automatic logic [CHAN_W-1:0] div255(logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, x} + (SUM_W+1)'(x >> CHAN_W) + (SUM_W+1)'(1);
        return t[SUM_W-1:CHAN_W];
    endfunction

endpackage

@@ src/sob_mix.sv @@
// ----------------------------------------------------------------------------
// sob_mix
// one colour channel: weighted sum registered, then divided by 255
// ----------------------------------------------------------------------------
module sob_mix
    import sob_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [CHAN_W-1:0] video,
    input  logic [CHAN_W-1:0] texel,
    input  logic [CHAN_W-1:0] alpha,
    output logic [CHAN_W-1:0] mixed
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    always_comb begin
        sum_next = SUM_W'(video) * SUM_W'(OPAQUE_MAX - alpha)
                 + SUM_W'(texel) * SUM_W'(alpha);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    assign mixed = div255(sum_reg);

endmodule

@@ src/scaled_overlay_alpha_blender.sv @@
// ----------------------------------------------------------------------------
// scaled_overlay_alpha_blender
// blends a nearest-neighbour scaled RGBA overlay onto a BGR video stream
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_*: tuser selects a texel load (0) or a video pixel (1).
//   A load in range writes one RGBA texel to the overlay store, with no output.
//   A pixel gives exactly one output beat on m_*, in input order.
//   Registers must be written through cfg_we / cfg_index / cfg_wdata only while idle; the block does not enforce it.
// Path: a pixel accepted into stage 1 reaches m_tvalid through the scale
//   products, store read, channel mix and output register, in that order.
// Throughput: one beat per cycle unless m_tready stalls; loads and pixels
//   mix freely; the single store port serves a texel write or read each cycle.
// Reset: aresetn (synchronous) empties the pipeline and restores register
//   defaults; the overlay store keeps whatever it held and must be loaded.
// Stall: with m_tready low each stage holds only while the one after it is
//   full, so bubbles still fill and s_tready drops once the pipe is full.
// ----------------------------------------------------------------------------
`include "scaled_overlay_alpha_blender_macros.svh"

module scaled_overlay_alpha_blender
    import sob_pkg::*;
#(
    parameter int unsigned OVERLAY_MAX_W   = OVERLAY_MAX_W_DEF,
    parameter int unsigned OVERLAY_MAX_H   = OVERLAY_MAX_H_DEF,
    parameter int unsigned FRAME_MAX_DIM   = FRAME_MAX_DIM_DEF,
    parameter int unsigned SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,  // pos_x, pos_y, red, green, blue, alpha
    input  logic [0:0]            s_tuser,  // action
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,  // out_blue, out_green, out_red
    // register writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int unsigned DEPTH = OVERLAY_MAX_W * OVERLAY_MAX_H;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned XW    = (OVERLAY_MAX_W > 1) ? $clog2(OVERLAY_MAX_W) : 1;
    localparam int unsigned YW    = (OVERLAY_MAX_H > 1) ? $clog2(OVERLAY_MAX_H) : 1;
    localparam int unsigned SCW   = PROD_W - SCALE_FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic [SIZE_W-1:0]  ovl_w_reg, ovl_h_reg;
    logic [DRAW_W-1:0]  draw_w_reg, draw_h_reg;
    logic [COORD_W-1:0] off_x_reg, off_y_reg;
    logic [SCALE_W-1:0] inv_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovl_w_reg     <= OVERLAY_SIZE_RST;
            ovl_h_reg     <= OVERLAY_SIZE_RST;
            draw_w_reg    <= DRAW_SIZE_RST;
            draw_h_reg    <= DRAW_SIZE_RST;
            off_x_reg     <= OFFSET_RST;
            off_y_reg     <= OFFSET_RST;
            inv_scale_reg <= INVERSE_SCALE_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_OVERLAY_WIDTH:  ovl_w_reg     <= cfg_wdata[SIZE_W-1:0];
                CFG_OVERLAY_HEIGHT: ovl_h_reg     <= cfg_wdata[SIZE_W-1:0];
                CFG_DRAW_WIDTH:     draw_w_reg    <= cfg_wdata[DRAW_W-1:0];
                CFG_DRAW_HEIGHT:    draw_h_reg    <= cfg_wdata[DRAW_W-1:0];
                CFG_OFFSET_X:       off_x_reg     <= cfg_wdata[COORD_W-1:0];
                CFG_OFFSET_Y:       off_y_reg     <= cfg_wdata[COORD_W-1:0];
                CFG_INVERSE_SCALE:  inv_scale_reg <= cfg_wdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- stage enables ----------------
    logic p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, m_tvalid_reg;
    logic en1, en2, en3, en4, en_out;

    assign en_out   = !m_tvalid_reg || m_tready;
    assign en4      = !p4_v_reg || en_out;
    assign en3      = !p3_v_reg || en4;
    assign en2      = !p2_v_reg || en3;
    assign en1      = !p1_v_reg || en2;
    assign s_tready = en1;

    // ---------------- stage 1: unpack, rectangle test ----------------
    logic [COORD_W-1:0] in_x, in_y, dx_next, dy_next;
    logic [TEXEL_W-1:0] in_rgba;
    logic               inside_next;

    assign in_x    = s_tdata[11:0];
    assign in_y    = s_tdata[23:12];
    assign in_rgba = s_tdata[55:24];  // red, green, blue, alpha from bit 0 up
    assign dx_next = in_x - off_x_reg;
    assign dy_next = in_y - off_y_reg;

    always_comb begin
        inside_next = (32'(in_x) < FRAME_MAX_DIM) && (32'(in_y) < FRAME_MAX_DIM)
                   && (in_x >= off_x_reg) && (in_y >= off_y_reg)
                   && ({1'b0, dx_next} < draw_w_reg) && ({1'b0, dy_next} < draw_h_reg);
    end

    logic               p1_act_reg, p1_inside_reg;
    logic [COORD_W-1:0] p1_x_reg, p1_y_reg, p1_dx_reg, p1_dy_reg;
    logic [TEXEL_W-1:0] p1_rgba_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
        end else if (en1) begin
            p1_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            p1_act_reg    <= s_tuser[0];
            p1_inside_reg <= inside_next;
            p1_x_reg      <= in_x;
            p1_y_reg      <= in_y;
            p1_dx_reg     <= dx_next;
            p1_dy_reg     <= dy_next;
            p1_rgba_reg   <= in_rgba;
        end
    end

    // ---------------- stage 2: scale products, load address ----------------
    logic               p2_act_reg, p2_inside_reg, p2_wok_reg;
    logic [PROD_W-1:0]  p2_mx_reg, p2_my_reg;
    logic [AW-1:0]      p2_waddr_reg;
    logic [TEXEL_W-1:0] p2_rgba_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_v_reg <= 1'b0;
        end else if (en2) begin
            p2_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            p2_act_reg    <= p1_act_reg;
            p2_inside_reg <= p1_inside_reg;
            p2_mx_reg     <= PROD_W'(p1_dx_reg) * PROD_W'(inv_scale_reg);
            p2_my_reg     <= PROD_W'(p1_dy_reg) * PROD_W'(inv_scale_reg);
            p2_wok_reg    <= (32'(p1_x_reg) < OVERLAY_MAX_W) && (32'(p1_y_reg) < OVERLAY_MAX_H);
            p2_waddr_reg  <= AW'(32'(p1_y_reg) * OVERLAY_MAX_W + 32'(p1_x_reg));
            p2_rgba_reg   <= p1_rgba_reg;
        end
    end

    // texel index: truncate to whole texels, clamp to the last one
    logic [COORD_W-1:0] last_x, last_y;
    logic [SCW-1:0]     scaled_x, scaled_y;
    logic [XW-1:0]      sx;
    logic [YW-1:0]      sy;
    logic [AW-1:0]      raddr, mem_addr;
    logic               mem_wr;

    assign last_x   = last_index(ovl_w_reg, OVERLAY_MAX_W);
    assign last_y   = last_index(ovl_h_reg, OVERLAY_MAX_H);
    assign scaled_x = p2_mx_reg[PROD_W-1:SCALE_FRAC_BITS];
    assign scaled_y = p2_my_reg[PROD_W-1:SCALE_FRAC_BITS];
    assign sx       = (scaled_x < SCW'(last_x)) ? XW'(scaled_x) : XW'(last_x);
    assign sy       = (scaled_y < SCW'(last_y)) ? YW'(scaled_y) : YW'(last_y);
    assign raddr    = AW'(32'(sy) * OVERLAY_MAX_W + 32'(sx));
    assign mem_wr   = p2_v_reg && (action_t'(p2_act_reg) == ACT_LOAD) && p2_wok_reg;
    assign mem_addr = mem_wr ? p2_waddr_reg : raddr;

    // ---------------- overlay store, one access a cycle ----------------
    // writes and reads leave stage 2 in beat order, so a read sees every earlier load
    logic [TEXEL_W-1:0] store_mem [DEPTH];
    logic [TEXEL_W-1:0] texel_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            if (mem_wr) begin
                store_mem[mem_addr] <= p2_rgba_reg;
            end
            texel_reg <= store_mem[mem_addr];
        end
    end

    // ---------------- stage 3: texel available ----------------
    logic               p3_inside_reg;
    logic [TEXEL_W-1:0] p3_video_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_v_reg <= 1'b0;
        end else if (en3) begin
            p3_v_reg <= p2_v_reg && (action_t'(p2_act_reg) == ACT_BLEND);
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            p3_inside_reg <= p2_inside_reg;
            p3_video_reg  <= p2_rgba_reg;
        end
    end

    // ---------------- stage 4: weighted sums ----------------
    logic               p4_pass_reg;
    logic [CHAN_W-1:0]  p4_r_reg, p4_g_reg, p4_b_reg;
    logic [CHAN_W-1:0]  mix_r, mix_g, mix_b;
    logic [CHAN_W-1:0]  tex_a;

    assign tex_a = texel_reg[31:24];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_v_reg <= 1'b0;
        end else if (en4) begin
            p4_v_reg <= p3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            p4_pass_reg <= !p3_inside_reg || (tex_a == '0);
            p4_r_reg    <= p3_video_reg[7:0];
            p4_g_reg    <= p3_video_reg[15:8];
            p4_b_reg    <= p3_video_reg[23:16];
        end
    end

    sob_mix u_mix_r (
        .aclk  (aclk),
        .en    (en4),
        .video (p3_video_reg[7:0]),
        .texel (texel_reg[7:0]),
        .alpha (tex_a),
        .mixed (mix_r)
    );

    sob_mix u_mix_g (
        .aclk  (aclk),
        .en    (en4),
        .video (p3_video_reg[15:8]),
        .texel (texel_reg[15:8]),
        .alpha (tex_a),
        .mixed (mix_g)
    );

    sob_mix u_mix_b (
        .aclk  (aclk),
        .en    (en4),
        .video (p3_video_reg[23:16]),
        .texel (texel_reg[23:16]),
        .alpha (tex_a),
        .mixed (mix_b)
    );

    // ---------------- output register ----------------
    logic [23:0] m_tdata_reg;
    logic [23:0] m_tdata_next;

    always_comb begin
        if (p4_pass_reg) begin
            m_tdata_next = {p4_r_reg, p4_g_reg, p4_b_reg};
        end else begin
            m_tdata_next = {mix_r, mix_g, mix_b};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en_out) begin
            m_tvalid_reg <= p4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- assertions ----------------
    `SOB_ASSERT_NOW(a_ready_when_out_empty, !m_tvalid_reg, s_tready, "s_tready low with empty output")
    `SOB_ASSERT_NEXT(a_mix_stage_holds, p4_v_reg && !en_out, p4_v_reg && $stable(p4_pass_reg), "mix stage lost a beat under stall")
    `SOB_ASSERT_NEXT(a_texel_holds, p3_v_reg && !en4, $stable(texel_reg), "texel read changed under stall")
    `SOB_ASSERT_NOW(a_result_from_pipe, $rose(m_tvalid_reg), $past(p4_v_reg), "result without a beat in the mix stage")
    `SOB_ASSERT_NEXT(a_load_no_result, en3 && p2_v_reg && (action_t'(p2_act_reg) == ACT_LOAD), !p3_v_reg, "texel load entered the blend stages")

endmodule

@@ tb/scaled_overlay_alpha_blender_tb.sv @@
// ----------------------------------------------------------------------------
// scaled_overlay_alpha_blender_tb
// Loads overlay texels and streams video pixels through the blender under
// random source gaps and sink stalls. A predictor keeps a copy of the
// registers and of the texels written so far, works out each blended pixel
// and compares every output beat with it. Register settings change between
// phases while the block is idle, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scaled_overlay_alpha_blender_tb
    import sob_pkg::*;
();

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned COORD_MAX      = 4095;

    class blend_predictor;
        logic [SIZE_W-1:0]  ov_w;
        logic [SIZE_W-1:0]  ov_h;
        logic [DRAW_W-1:0]  dr_w;
        logic [DRAW_W-1:0]  dr_h;
        logic [COORD_W-1:0] off_x;
        logic [COORD_W-1:0] off_y;
        logic [SCALE_W-1:0] inv_scale;
        logic [TEXEL_W-1:0] texels [int];
        logic [23:0]        pending_pixels [$];
        int unsigned        pixel_errors;

        function new();
            ov_w         = OVERLAY_SIZE_RST;
            ov_h         = OVERLAY_SIZE_RST;
            dr_w         = DRAW_SIZE_RST;
            dr_h         = DRAW_SIZE_RST;
            off_x        = OFFSET_RST;
            off_y        = OFFSET_RST;
            inv_scale    = INVERSE_SCALE_RST;
            pixel_errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_OVERLAY_WIDTH:  ov_w      = val[SIZE_W-1:0];
                CFG_OVERLAY_HEIGHT: ov_h      = val[SIZE_W-1:0];
                CFG_DRAW_WIDTH:     dr_w      = val[DRAW_W-1:0];
                CFG_DRAW_HEIGHT:    dr_h      = val[DRAW_W-1:0];
                CFG_OFFSET_X:       off_x     = val[COORD_W-1:0];
                CFG_OFFSET_Y:       off_y     = val[COORD_W-1:0];
                CFG_INVERSE_SCALE:  inv_scale = val[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // usable overlay size along one axis
        function int unsigned usable_size(logic [SIZE_W-1:0] size, int unsigned max_size);
            if (size == 0)
                return 1;
            if (size > max_size)
                return max_size;
            return size;
        endfunction

        // store address of the texel a frame pixel picks, 0 when outside the rectangle
        function bit texel_addr(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                output int addr);
            longint unsigned dx, dy, sx, sy, wl, hl;
            addr = 0;
            if (px < off_x || py < off_y)
                return 0;
            dx = px - off_x;
            dy = py - off_y;
            if (dx >= dr_w || dy >= dr_h)
                return 0;
            wl = usable_size(ov_w, OVERLAY_MAX_W_DEF) - 1;
            hl = usable_size(ov_h, OVERLAY_MAX_H_DEF) - 1;
            sx = (dx * inv_scale) >> SCALE_FRAC_BITS_DEF;
            sy = (dy * inv_scale) >> SCALE_FRAC_BITS_DEF;
            if (sx > wl)
                sx = wl;
            if (sy > hl)
                sy = hl;
            addr = int'(sy * OVERLAY_MAX_W_DEF + sx);
            return 1;
        endfunction

        function logic [CHAN_W-1:0] mix(int unsigned video, int unsigned tex, int unsigned a);
            return CHAN_W'((video * (255 - a) + tex * a) / 255);
        endfunction

        function void note_beat(action_t act, logic [55:0] beat);
            logic [COORD_W-1:0] px, py;
            logic [CHAN_W-1:0]  r, g, b, a, ta, out_r, out_g, out_b;
            logic [TEXEL_W-1:0] tex;
            int                 addr;
            px = beat[11:0];
            py = beat[23:12];
            r  = beat[31:24];
            g  = beat[39:32];
            b  = beat[47:40];
            a  = beat[55:48];
            if (act == ACT_LOAD) begin
                if (px < OVERLAY_MAX_W_DEF && py < OVERLAY_MAX_H_DEF)
                    texels[int'(py) * OVERLAY_MAX_W_DEF + int'(px)] = {a, b, g, r};
            end else begin
                out_r = r;
                out_g = g;
                out_b = b;
                if (texel_addr(px, py, addr)) begin
                    tex = texels.exists(addr) ? texels[addr] : '0;
                    ta  = tex[31:24];
                    if (ta != 0) begin
                        out_r = mix(r, tex[7:0], ta);
                        out_g = mix(g, tex[15:8], ta);
                        out_b = mix(b, tex[23:16], ta);
                    end
                end
                pending_pixels.push_back({out_r, out_g, out_b});
            end
        endfunction

        function void check_pixel(logic [23:0] got);
            logic [23:0] want;
            if (pending_pixels.size() == 0) begin
                pixel_errors++;
                if (pixel_errors <= MAX_REPORTS)
                    $display("unexpected output beat: b=%0d g=%0d r=%0d",
                             got[7:0], got[15:8], got[23:16]);
            end else begin
                want = pending_pixels.pop_front();
                if (got[7:0] !== want[7:0] || got[15:8] !== want[15:8] ||
                    got[23:16] !== want[23:16]) begin
                    pixel_errors++;
                    if (pixel_errors <= MAX_REPORTS)
                        $display("pixel mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                                 want[7:0], want[15:8], want[23:16],
                                 got[7:0], got[15:8], got[23:16]);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [55:0]           s_tdata;   // pos_x, pos_y, red, green, blue, alpha
    logic [0:0]            s_tuser;   // action
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;   // out_blue, out_green, out_red
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    blend_predictor pred = new();
    bit             idle_on;
    int unsigned    quiet_cycles;

    scaled_overlay_alpha_blender u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // mostly short pauses, now and then a long one
    function automatic int unsigned pause_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result sink with random stalls
    initial begin : sink
        int unsigned stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0)
                    stall_left = pause_len();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            pred.check_pixel(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_beat(action_t act, int unsigned x, int unsigned y,
                             int unsigned r, int unsigned g, int unsigned b, int unsigned a);
        int unsigned gap;
        logic [55:0] beat;
        gap  = (idle_on && $urandom_range(0, 3) == 0) ? pause_len() : 0;
        beat = {CHAN_W'(a), CHAN_W'(b), CHAN_W'(g), CHAN_W'(r), COORD_W'(y), COORD_W'(x)};
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        s_tuser  <= act;
        forever begin
            @(posedge aclk);
            if (s_tready)
                break;
        end
        pred.note_beat(act, beat);
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // wait for every outstanding pixel, then let trailing loads retire
    task automatic settle();
        while (pred.pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        pred.set_reg(idx, val);
    endtask

    task automatic program_regs(int unsigned ow, int unsigned oh, int unsigned dw,
                                int unsigned dh, int unsigned ox, int unsigned oy,
                                int unsigned scale);
        write_reg(CFG_OVERLAY_WIDTH, CFG_DATA_W'(ow));
        write_reg(CFG_OVERLAY_HEIGHT, CFG_DATA_W'(oh));
        write_reg(CFG_DRAW_WIDTH, CFG_DATA_W'(dw));
        write_reg(CFG_DRAW_HEIGHT, CFG_DATA_W'(dh));
        write_reg(CFG_OFFSET_X, CFG_DATA_W'(ox));
        write_reg(CFG_OFFSET_Y, CFG_DATA_W'(oy));
        write_reg(CFG_INVERSE_SCALE, CFG_DATA_W'(scale));
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_texel_rand(int unsigned x, int unsigned y);
        int unsigned sel, a;
        sel = $urandom_range(0, 9);
        a   = (sel < 2) ? 0 : (sel < 4) ? 255 : $urandom_range(0, 255);
        send_beat(ACT_LOAD, x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), a);
    endtask

    // a texel the pixel would pick is loaded first if it was never written
    task automatic send_pixel(int unsigned x, int unsigned y);
        int addr;
        if (pred.texel_addr(COORD_W'(x), COORD_W'(y), addr) && !pred.texels.exists(addr))
            load_texel_rand(addr % OVERLAY_MAX_W_DEF, addr / OVERLAY_MAX_W_DEF);
        send_beat(ACT_BLEND, x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // mostly inside the rectangle, some just outside its edges, some anywhere
    function automatic int unsigned pick_coord(int unsigned lo, int unsigned span);
        int unsigned sel, hi;
        int          v;
        sel = $urandom_range(0, 99);
        if (span != 0 && sel < 80) begin
            hi = lo + span - 1;
            if (hi > COORD_MAX)
                hi = COORD_MAX;
            return $urandom_range(lo, hi);
        end
        if (sel < 92) begin
            v = $urandom_range(0, 1) ? int'(lo) - 1 : int'(lo + span);
            if (v < 0)
                v = 0;
            if (v > int'(COORD_MAX))
                v = COORD_MAX;
            return v;
        end
        return $urandom_range(0, COORD_MAX);
    endfunction

    task automatic run_phase(int unsigned n_items);
        int unsigned ew, eh;
        ew = pred.usable_size(pred.ov_w, OVERLAY_MAX_W_DEF);
        eh = pred.usable_size(pred.ov_h, OVERLAY_MAX_H_DEF);
        // small overlays get a full load sequence up front
        if (ew * eh <= 64) begin
            for (int unsigned y = 0; y < eh; y++)
                for (int unsigned x = 0; x < ew; x++)
                    load_texel_rand(x, y);
        end
        for (int unsigned i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                if ($urandom_range(0, 9) < 8)
                    load_texel_rand($urandom_range(0, ew - 1), $urandom_range(0, eh - 1));
                else
                    load_texel_rand($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            end else begin
                send_pixel(pick_coord(pred.off_x, pred.dr_w), pick_coord(pred.off_y, pred.dr_h));
            end
            // source holds off until the pipe has fully emptied
            if ($urandom_range(0, 149) == 0) begin
                drop_valid();
                settle();
            end
        end
        drop_valid();
        settle();
    endtask

    initial begin : stimulus
        int unsigned ow, oh, dw, dh, ox, oy, scale, sel;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACT_LOAD;
        cfg_we       = 1'b0;
        cfg_index    = CFG_OVERLAY_WIDTH;
        cfg_wdata    = '0;
        idle_on      = 1'b1;
        quiet_cycles = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default registers: 1x1 overlay drawn at the origin
        send_beat(ACT_LOAD, 0, 0, 0, 0, 0, 0);            // transparent texel
        send_beat(ACT_BLEND, 0, 0, 255, 255, 255, 255);
        send_beat(ACT_BLEND, 1, 0, 12, 34, 56, 0);        // just right of the rectangle
        send_beat(ACT_BLEND, 0, 1, 78, 90, 12, 0);        // just below it
        send_beat(ACT_LOAD, 0, 0, 255, 255, 255, 255);    // fully opaque
        send_beat(ACT_BLEND, 0, 0, 0, 0, 0, 0);
        send_beat(ACT_LOAD, 0, 0, 0, 0, 0, 255);
        send_beat(ACT_BLEND, 0, 0, 255, 255, 255, 0);
        send_beat(ACT_LOAD, 0, 0, 200, 100, 50, 1);       // faintest alpha
        send_beat(ACT_BLEND, 0, 0, 10, 20, 30, 128);
        send_beat(ACT_LOAD, 0, 0, 17, 34, 51, 254);
        send_beat(ACT_BLEND, 0, 0, 255, 0, 128, 0);
        // loads beyond the store must be dropped without aliasing
        send_beat(ACT_LOAD, 256, 0, 255, 255, 255, 255);
        send_beat(ACT_LOAD, 0, 256, 255, 255, 255, 255);
        send_beat(ACT_LOAD, 4095, 4095, 255, 255, 255, 255);
        send_beat(ACT_BLEND, 0, 0, 90, 90, 90, 255);
        send_beat(ACT_BLEND, 4095, 4095, 255, 255, 255, 255);
        send_beat(ACT_BLEND, 4095, 0, 1, 2, 3, 4);
        send_beat(ACT_BLEND, 0, 4095, 5, 6, 7, 8);
        drop_valid();
        settle();

        // zero overlay size, largest rectangle, largest scale
        idle_on = 1'b0;
        program_regs(0, 0, 8191, 8191, 0, 0, 24'hFFFFFF);
        run_phase(80);
        // oversized overlay clamped to the store, full-frame rectangle
        idle_on = 1'b1;
        program_regs(511, 300, 4096, 4096, 0, 0, 4096);
        run_phase(80);
        // empty rectangle: every pixel passes through
        program_regs(8, 8, 0, 20, 100, 100, 65536);
        run_phase(80);
        // one-pixel rectangle at the far corner, zero scale
        idle_on = 1'b0;
        program_regs(256, 256, 1, 1, 4095, 4095, 0);
        run_phase(80);
        idle_on = 1'b1;
        program_regs(4, 3, 16, 12, 10, 20, 16384);
        run_phase(80);

        for (int k = 0; k < 8; k++) begin
            idle_on = (k % 3 != 0);
            sel = $urandom_range(0, 9);
            ow  = (sel < 7) ? $urandom_range(1, 16) : (sel < 8) ? 0 :
                  (sel < 9) ? $urandom_range(257, 511) : $urandom_range(17, 256);
            sel = $urandom_range(0, 9);
            oh  = (sel < 7) ? $urandom_range(1, 16) : (sel < 8) ? 0 :
                  (sel < 9) ? $urandom_range(257, 511) : $urandom_range(17, 256);
            sel = $urandom_range(0, 19);
            dw  = (sel < 16) ? $urandom_range(1, 64) : (sel < 19) ? $urandom_range(65, 8191) : 0;
            sel = $urandom_range(0, 19);
            dh  = (sel < 16) ? $urandom_range(1, 64) : (sel < 19) ? $urandom_range(65, 8191) : 0;
            ox  = $urandom_range(0, 4095);
            oy  = $urandom_range(0, 4095);
            sel = $urandom_range(0, 9);
            if (sel < 6 && dw != 0) begin
                scale = (pred.usable_size(SIZE_W'(ow), OVERLAY_MAX_W_DEF) << SCALE_FRAC_BITS_DEF)
                        / dw + $urandom_range(0, 3);
                if (scale > 24'hFFFFFF)
                    scale = 24'hFFFFFF;
            end else if (sel < 8) begin
                scale = $urandom_range(0, 24'hFFFFFF);
            end else begin
                scale = $urandom_range(0, 1 << 18);
            end
            program_regs(ow, oh, dw, dh, ox, oy, scale);
            run_phase(100);
        end

        drop_valid();
        settle();
        if (pred.pixel_errors == 0 && pred.pending_pixels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
